// ===== design/rpa_pkg.sv =====
// Shared types and codes of the reference-counted page allocator.
package rpa_pkg;

  localparam int PAGE_BITS = 12;
  localparam int COUNT_OUT_BITS = 16;
  localparam int FREE_OUT_BITS = 13;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS = 12;
  localparam int REF_LIMIT = 4096;

  localparam logic [2:0] REQ_ALLOC = 3'd0;
  localparam logic [2:0] REQ_FREE  = 3'd1;
  localparam logic [2:0] REQ_INC   = 3'd2;
  localparam logic [2:0] REQ_DEC   = 3'd3;
  localparam logic [2:0] REQ_READ  = 3'd4;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_BAD   = 3'd1;
  localparam logic [2:0] ST_EMPTY = 3'd2;
  localparam logic [2:0] ST_ZERO  = 3'd3;
  localparam logic [2:0] ST_FULL  = 3'd4;
  localparam logic [2:0] ST_LIMIT = 3'd5;

  localparam logic [2:0] KIND_ALLOC = 3'd0;
  localparam logic [2:0] KIND_FREE  = 3'd1;
  localparam logic [2:0] KIND_INC   = 3'd2;
  localparam logic [2:0] KIND_DEC   = 3'd3;
  localparam logic [2:0] KIND_READ  = 3'd4;
  localparam logic [2:0] KIND_BAD   = 3'd5;
  localparam logic [2:0] KIND_ZERO  = 3'd6;
  localparam logic [2:0] KIND_NOP   = 3'd7;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_FIRST_PAGE = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ZERO_EN    = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ZERO_INDEX = 2'd2;

  typedef struct packed {
    logic [2:0]           req_type;
    logic [PAGE_BITS-1:0] page_index;
  } req_t;

  typedef struct packed {
    logic [2:0]                status;
    logic [PAGE_BITS-1:0]      granted_page;
    logic [COUNT_OUT_BITS-1:0] ref_count;
    logic                      page_released;
    logic [FREE_OUT_BITS-1:0]  free_count;
  } rsp_t;

  typedef struct packed {
    logic [2:0]           kind;
    logic [PAGE_BITS-1:0] page;
  } work_t;

endpackage

// ===== design/rpa_front.sv =====
// Front end: configuration registers and request classification.
module rpa_front #(
  parameter int NUM_PAGES = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [rpa_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [rpa_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  rpa_pkg::req_t                       req,
  output rpa_pkg::work_t                      work
);

  logic [rpa_pkg::PAGE_BITS-1:0] first_page;
  logic                          zero_page_enable;
  logic [rpa_pkg::PAGE_BITS-1:0] zero_page_index;
  logic                          page_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_page       <= '0;
      zero_page_enable <= 1'b0;
      zero_page_index  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rpa_pkg::CFG_FIRST_PAGE: first_page <= cfg_data[rpa_pkg::PAGE_BITS-1:0];
        rpa_pkg::CFG_ZERO_EN:    zero_page_enable <= cfg_data[0];
        rpa_pkg::CFG_ZERO_INDEX: zero_page_index <= cfg_data[rpa_pkg::PAGE_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign page_ok = (req.page_index >= first_page) && (32'(req.page_index) < NUM_PAGES);

  always_comb begin
    work.page = req.page_index;
    case (req.req_type)
      rpa_pkg::REQ_ALLOC: work.kind = rpa_pkg::KIND_ALLOC;
      rpa_pkg::REQ_FREE: begin
        if (!page_ok) begin
          work.kind = rpa_pkg::KIND_BAD;
        end else if (zero_page_enable && req.page_index == zero_page_index) begin
          work.kind = rpa_pkg::KIND_ZERO;
        end else begin
          work.kind = rpa_pkg::KIND_FREE;
        end
      end
      rpa_pkg::REQ_INC:  work.kind = page_ok ? rpa_pkg::KIND_INC : rpa_pkg::KIND_BAD;
      rpa_pkg::REQ_DEC:  work.kind = page_ok ? rpa_pkg::KIND_DEC : rpa_pkg::KIND_BAD;
      rpa_pkg::REQ_READ: work.kind = page_ok ? rpa_pkg::KIND_READ : rpa_pkg::KIND_BAD;
      default:           work.kind = rpa_pkg::KIND_NOP;
    endcase
  end

endmodule

// ===== design/rpa_queue.sv =====
// Two-entry queue of classified items between front and back.
module rpa_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rpa_pkg::work_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output rpa_pkg::work_t head
);

  rpa_pkg::work_t slots [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  assign full      = fill[1];
  assign not_empty = (fill != 2'd0);
  assign head      = slots[rd_ptr];

endmodule

// ===== design/rpa_back.sv =====
// Back end: count and free-stack memories, request execution, result register.
module rpa_back #(
  parameter int NUM_PAGES  = 4096,
  parameter int COUNT_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  input  rpa_pkg::work_t item,
  output logic           pop,
  output logic           ready_for_items,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output rpa_pkg::rsp_t  rsp
);

  localparam int REF_DEPTH = (NUM_PAGES < rpa_pkg::REF_LIMIT) ? NUM_PAGES : rpa_pkg::REF_LIMIT;
  localparam int RW = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;
  localparam int SW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int DW = $clog2(NUM_PAGES + 1);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [COUNT_BITS-1:0]         ref_mem [REF_DEPTH];
  logic [rpa_pkg::PAGE_BITS-1:0] stk_mem [NUM_PAGES];

  logic [1:0]                    state;
  logic [1:0]                    state_next;
  logic [RW-1:0]                 clr_idx;
  logic [DW-1:0]                 depth;
  logic [DW-1:0]                 depth_next;
  rpa_pkg::work_t                cur;
  logic [COUNT_BITS-1:0]         ref_rdata;
  logic [rpa_pkg::PAGE_BITS-1:0] stk_rdata;

  logic                          fire;
  logic                          ref_we;
  logic [RW-1:0]                 ref_waddr;
  logic [COUNT_BITS-1:0]         ref_wdata;
  logic                          stk_we;
  logic [2:0]                    status;
  logic [rpa_pkg::PAGE_BITS-1:0] granted;
  logic [COUNT_BITS-1:0]         count;
  logic                          released;
  logic [COUNT_BITS-1:0]         dec_val;

  assign pop             = (state == S_IDLE) && item_valid;
  assign ready_for_items = (state != S_CLEAR);
  assign fire            = (state == S_EXEC) && (!rsp_valid || rsp_ready);
  assign dec_val         = (ref_rdata != '0) ? ref_rdata - COUNT_BITS'(1) : '0;

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_idx == RW'(REF_DEPTH - 1)) state_next = S_IDLE;
      S_IDLE:  if (pop) state_next = S_EXEC;
      S_EXEC:  if (fire) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    status     = rpa_pkg::ST_OK;
    granted    = '0;
    count      = '0;
    released   = 1'b0;
    depth_next = depth;
    ref_we     = 1'b0;
    ref_waddr  = RW'(cur.page);
    ref_wdata  = '0;
    stk_we     = 1'b0;
    case (cur.kind)
      rpa_pkg::KIND_ALLOC: begin
        if (depth == '0) begin
          status = rpa_pkg::ST_EMPTY;
        end else begin
          depth_next = depth - DW'(1);
          granted    = stk_rdata;
          count      = COUNT_BITS'(1);
          ref_we     = 1'b1;
          ref_waddr  = RW'(stk_rdata);
          ref_wdata  = COUNT_BITS'(1);
        end
      end
      rpa_pkg::KIND_FREE: begin
        count     = dec_val;
        ref_we    = 1'b1;
        ref_wdata = dec_val;
        if (dec_val == '0) begin
          if (32'(depth) >= NUM_PAGES) begin
            status = rpa_pkg::ST_FULL;
          end else begin
            stk_we     = 1'b1;
            depth_next = depth + DW'(1);
            released   = 1'b1;
          end
        end
      end
      rpa_pkg::KIND_INC: begin
        if (ref_rdata == {COUNT_BITS{1'b1}}) begin
          status = rpa_pkg::ST_LIMIT;
          count  = ref_rdata;
        end else begin
          count     = ref_rdata + COUNT_BITS'(1);
          ref_we    = 1'b1;
          ref_wdata = ref_rdata + COUNT_BITS'(1);
        end
      end
      rpa_pkg::KIND_DEC: begin
        if (ref_rdata == '0) begin
          status = rpa_pkg::ST_LIMIT;
        end else begin
          count     = dec_val;
          ref_we    = 1'b1;
          ref_wdata = dec_val;
        end
      end
      rpa_pkg::KIND_READ: count = ref_rdata;
      rpa_pkg::KIND_BAD:  status = rpa_pkg::ST_BAD;
      rpa_pkg::KIND_ZERO: begin
        status = rpa_pkg::ST_ZERO;
        count  = ref_rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      depth     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_idx <= clr_idx + RW'(1);
      end
      if (fire) begin
        depth     <= depth_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= item;
    end
    if (fire) begin
      rsp.status        <= status;
      rsp.granted_page  <= granted;
      rsp.ref_count     <= rpa_pkg::COUNT_OUT_BITS'(count);
      rsp.page_released <= released;
      rsp.free_count    <= rpa_pkg::FREE_OUT_BITS'(depth_next);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ref_rdata <= ref_mem[RW'(item.page)];
      stk_rdata <= stk_mem[SW'(depth - DW'(1))];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      ref_mem[clr_idx] <= '0;
    end else if (fire && ref_we) begin
      ref_mem[ref_waddr] <= ref_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && stk_we) begin
      stk_mem[SW'(depth)] <= cur.page;
    end
  end

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    32'(depth) <= NUM_PAGES)
    else $error("free stack depth beyond page count");

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !pop)
    else $error("item taken during clearing pass");

  a_exec_returns: assert property (@(posedge clk) disable iff (rst)
    fire |=> (state == S_IDLE) && rsp_valid)
    else $error("executed item did not produce a result");

  a_depth_step: assert property (@(posedge clk) disable iff (rst)
    (state != S_EXEC) |=> depth == $past(depth))
    else $error("stack depth moved outside execution");

endmodule

// ===== design/refcounted_page_allocator_core.sv =====
// Top level of the reference-counted page allocator.
// In the execution unit a request first reads the page's count and the top
// of the free stack from their memories; then the update is applied, the
// memories are written back and the result register is loaded.
// A stalled result holds the execution unit; up to two further requests wait
// in the queue behind it. After reset a clearing pass zeroes the count memory,
// one entry a cycle, over its min(NUM_PAGES, 4096) entries, with req_ready
// low throughout; configuration writes are taken at any time.
module refcounted_page_allocator_core #(
  parameter int NUM_PAGES  = 4096,
  parameter int COUNT_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [rpa_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [rpa_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                req_valid,
  output logic                                req_ready,
  input  rpa_pkg::req_t                       req,
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output rpa_pkg::rsp_t                       rsp
);

  rpa_pkg::work_t work;
  rpa_pkg::work_t head;
  logic           q_full;
  logic           q_not_empty;
  logic           q_pop;
  logic           back_ready;

  assign req_ready = back_ready && !q_full;

  rpa_front #(
    .NUM_PAGES(NUM_PAGES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .work      (work)
  );

  rpa_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (req_valid && req_ready),
    .push_item (work),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (head)
  );

  rpa_back #(
    .NUM_PAGES (NUM_PAGES),
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (q_not_empty),
    .item            (head),
    .pop             (q_pop),
    .ready_for_items (back_ready),
    .rsp_valid       (rsp_valid),
    .rsp_ready       (rsp_ready),
    .rsp             (rsp)
  );

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the reference-counted page allocator core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAGE_TOTAL = 4096;
  localparam logic [15:0] CNT_MAX = 16'hFFFF;
  localparam logic [rpa_pkg::CFG_INDEX_BITS-1:0] CFG_UNUSED = 2'd3;
  localparam logic [2:0] REQ_FIRST_RESERVED = 3'd5;
  localparam logic [2:0] REQ_LAST_RESERVED = 3'd7;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_PER_PHASE = 150;
  localparam int FILL_PAGES = 48;
  localparam int CLIMB_STEPS = 6;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [rpa_pkg::CFG_INDEX_BITS-1:0] cfg_index;
  logic [rpa_pkg::CFG_DATA_BITS-1:0] cfg_data;
  logic req_valid;
  logic req_ready;
  rpa_pkg::req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rpa_pkg::rsp_t rsp;

  logic [rpa_pkg::PAGE_BITS-1:0] free_list [PAGE_TOTAL];
  logic [15:0] page_refs [PAGE_TOTAL];
  int unsigned free_depth;
  logic [rpa_pkg::PAGE_BITS-1:0] cfg_first_page;
  logic cfg_zero_en;
  logic [rpa_pkg::PAGE_BITS-1:0] cfg_zero_index;

  rpa_pkg::rsp_t due_results [$];
  logic [rpa_pkg::PAGE_BITS-1:0] held_pages [$];

  int send_idle_pct;
  int rsp_stall_pct;
  int mismatches;
  int reqs_sent;
  int results_seen;
  int cfg_writes;
  int unsigned peak_depth;
  int idle_cycles;

  refcounted_page_allocator_core dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic rpa_pkg::rsp_t apply_page_request(rpa_pkg::req_t item);
    rpa_pkg::rsp_t o;
    logic [rpa_pkg::PAGE_BITS-1:0] pg;
    o = '0;
    o.status = rpa_pkg::ST_OK;
    pg = item.page_index;
    case (item.req_type)
      rpa_pkg::REQ_ALLOC: begin
        if (free_depth == 0) begin
          o.status = rpa_pkg::ST_EMPTY;
        end else begin
          free_depth--;
          o.granted_page = free_list[free_depth];
          page_refs[o.granted_page] = 16'd1;
          o.ref_count = 16'd1;
        end
      end
      rpa_pkg::REQ_FREE, rpa_pkg::REQ_INC, rpa_pkg::REQ_DEC, rpa_pkg::REQ_READ: begin
        if (pg < cfg_first_page) begin
          o.status = rpa_pkg::ST_BAD;
        end else begin
          case (item.req_type)
            rpa_pkg::REQ_FREE: begin
              if (cfg_zero_en && pg == cfg_zero_index) begin
                o.status = rpa_pkg::ST_ZERO;
              end else begin
                if (page_refs[pg] != 0) page_refs[pg]--;
                if (page_refs[pg] == 0) begin
                  if (free_depth >= PAGE_TOTAL) begin
                    o.status = rpa_pkg::ST_FULL;
                  end else begin
                    free_list[free_depth] = pg;
                    free_depth++;
                    o.page_released = 1'b1;
                  end
                end
              end
            end
            rpa_pkg::REQ_INC: begin
              if (page_refs[pg] == CNT_MAX) o.status = rpa_pkg::ST_LIMIT;
              else page_refs[pg]++;
            end
            rpa_pkg::REQ_DEC: begin
              if (page_refs[pg] == 0) o.status = rpa_pkg::ST_LIMIT;
              else page_refs[pg]--;
            end
            default: ;
          endcase
          o.ref_count = page_refs[pg];
        end
      end
      default: ;
    endcase
    o.free_count = 13'(free_depth);
    if (free_depth > peak_depth) peak_depth = free_depth;
    return o;
  endfunction

  function automatic void match_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) $display("mismatch in %s: expected %0h, got %0h", name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    rpa_pkg::rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      results_seen++;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: status %0d page %0h count %0h",
                                       rsp.status, rsp.granted_page, rsp.ref_count);
      end else begin
        want = due_results.pop_front();
        match_field("status", 16'(want.status), 16'(rsp.status));
        match_field("granted_page", 16'(want.granted_page), 16'(rsp.granted_page));
        match_field("ref_count", want.ref_count, rsp.ref_count);
        match_field("page_released", 16'(want.page_released), 16'(rsp.page_released));
        match_field("free_count", 16'(want.free_count), 16'(rsp.free_count));
      end
    end
  end

  always @(negedge clk) begin
    rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
  end

  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", idle_cycles);
        $display("refcounted_page_allocator_core test failed");
        $finish;
      end
    end
  end

  task automatic send_req(input logic [2:0] op, input logic [rpa_pkg::PAGE_BITS-1:0] pg,
                          output rpa_pkg::rsp_t want);
    int gap;
    rpa_pkg::req_t item;
    item.req_type = op;
    item.page_index = pg;
    gap = ($urandom_range(0, 99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
    @(negedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    do @(posedge clk); while (!req_ready);
    want = apply_page_request(item);
    due_results.push_back(want);
    reqs_sent++;
  endtask

  task automatic hold_requests();
    @(negedge clk);
    req_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input logic [rpa_pkg::CFG_INDEX_BITS-1:0] idx,
                         input logic [rpa_pkg::CFG_DATA_BITS-1:0] d);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    cfg_writes++;
    case (idx)
      rpa_pkg::CFG_FIRST_PAGE: cfg_first_page = d;
      rpa_pkg::CFG_ZERO_EN:    cfg_zero_en = d[0];
      rpa_pkg::CFG_ZERO_INDEX: cfg_zero_index = d;
      default: ;
    endcase
  endtask

  task automatic reconfigure(input logic [rpa_pkg::PAGE_BITS-1:0] first, input logic zen,
                             input logic [rpa_pkg::PAGE_BITS-1:0] zidx);
    logic [rpa_pkg::CFG_DATA_BITS-1:0] junk;
    junk = 12'($urandom_range(0, 4095));
    hold_requests();
    put_reg(rpa_pkg::CFG_FIRST_PAGE, first);
    put_reg(rpa_pkg::CFG_ZERO_EN, {junk[rpa_pkg::CFG_DATA_BITS-1:1], zen});
    put_reg(rpa_pkg::CFG_ZERO_INDEX, zidx);
    put_reg(CFG_UNUSED, ~junk);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_pacing(input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    rsp_stall_pct = stall_pct;
  endtask

  function automatic logic [rpa_pkg::PAGE_BITS-1:0] pick_page();
    int src;
    int v;
    src = $urandom_range(0, 9);
    if (src < 5 && held_pages.size() > 0) return held_pages[$urandom_range(0, held_pages.size() - 1)];
    if (src < 7) begin
      if ($urandom_range(0, 3) == 0 && cfg_first_page > 0) return cfg_first_page - 1'b1;
      v = int'(cfg_first_page) + int'($urandom_range(0, 3));
      if (v > PAGE_TOTAL - 1) v = PAGE_TOTAL - 1;
      return v[rpa_pkg::PAGE_BITS-1:0];
    end
    if (src == 7) return cfg_zero_index;
    return 12'($urandom_range(0, PAGE_TOTAL - 1));
  endfunction

  task automatic test_directed();
    rpa_pkg::rsp_t r;
    set_pacing(0, 0);
    send_req(rpa_pkg::REQ_ALLOC, 12'd0, r);
    send_req(rpa_pkg::REQ_READ, 12'd0, r);
    send_req(rpa_pkg::REQ_DEC, 12'hFFF, r);
    send_req(rpa_pkg::REQ_INC, 12'hFFF, r);
    send_req(rpa_pkg::REQ_FREE, 12'hFFF, r);
    send_req(rpa_pkg::REQ_FREE, 12'hFFF, r);
    send_req(rpa_pkg::REQ_ALLOC, 12'hABC, r);
    send_req(rpa_pkg::REQ_ALLOC, 12'd0, r);
    for (int op = int'(REQ_FIRST_RESERVED); op <= int'(REQ_LAST_RESERVED); op++)
      send_req(3'(op), 12'h555, r);
    reconfigure(12'd100, 1'b1, 12'd200);
    send_req(rpa_pkg::REQ_READ, 12'd99, r);
    send_req(rpa_pkg::REQ_FREE, 12'd99, r);
    send_req(rpa_pkg::REQ_FREE, 12'd0, r);
    send_req(rpa_pkg::REQ_INC, 12'd100, r);
    send_req(rpa_pkg::REQ_INC, 12'd200, r);
    send_req(rpa_pkg::REQ_FREE, 12'd200, r);
    send_req(rpa_pkg::REQ_FREE, 12'hFFF, r);
    send_req(rpa_pkg::REQ_DEC, 12'd100, r);
    send_req(rpa_pkg::REQ_READ, 12'd100, r);
  endtask

  task automatic test_stack_fill();
    rpa_pkg::rsp_t r;
    int start;
    logic [rpa_pkg::PAGE_BITS-1:0] grabbed;
    set_pacing(0, 0);
    reconfigure(12'd0, 1'b0, 12'($urandom_range(0, 4095)));
    start = $urandom_range(0, PAGE_TOTAL - 1);
    for (int i = 0; i < FILL_PAGES; i++)
      send_req(rpa_pkg::REQ_FREE, 12'(start + i), r);
    send_req(rpa_pkg::REQ_FREE, 12'(start), r);
    send_req(rpa_pkg::REQ_ALLOC, 12'd0, r);
    grabbed = r.granted_page;
    send_req(rpa_pkg::REQ_FREE, grabbed ^ 12'h001, r);
    send_req(rpa_pkg::REQ_FREE, grabbed, r);
  endtask

  task automatic test_count_limit();
    rpa_pkg::rsp_t r;
    logic [rpa_pkg::PAGE_BITS-1:0] pg;
    set_pacing(0, 0);
    pg = 12'($urandom_range(0, PAGE_TOTAL - 1));
    repeat (CLIMB_STEPS) send_req(rpa_pkg::REQ_INC, pg, r);
    while (page_refs[pg] != 16'd0) send_req(rpa_pkg::REQ_DEC, pg, r);
    send_req(rpa_pkg::REQ_DEC, pg, r);
    send_req(rpa_pkg::REQ_DEC, pg, r);
    send_req(rpa_pkg::REQ_INC, pg, r);
    send_req(rpa_pkg::REQ_READ, pg, r);
  endtask

  task automatic run_random_phase(input int idle_pct, input int stall_pct,
                                  input logic [rpa_pkg::PAGE_BITS-1:0] first, input logic zen,
                                  input logic [rpa_pkg::PAGE_BITS-1:0] zidx,
                                  input bit pause_midway);
    rpa_pkg::rsp_t r;
    int pick;
    logic [2:0] op;
    logic [rpa_pkg::PAGE_BITS-1:0] pg;
    reconfigure(first, zen, zidx);
    set_pacing(idle_pct, stall_pct);
    for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
      if (pause_midway && n == RANDOM_PER_PHASE / 2) hold_requests();
      pick = $urandom_range(0, 99);
      pg = pick_page();
      if (pick < 30) begin
        op = rpa_pkg::REQ_ALLOC;
        pg = 12'($urandom_range(0, PAGE_TOTAL - 1));
      end else if (pick < 55) op = rpa_pkg::REQ_FREE;
      else if (pick < 65) op = rpa_pkg::REQ_INC;
      else if (pick < 75) op = rpa_pkg::REQ_DEC;
      else if (pick < 85) op = rpa_pkg::REQ_READ;
      else if (pick < 92) op = 3'($urandom_range(REQ_FIRST_RESERVED, REQ_LAST_RESERVED));
      else op = 3'($urandom_range(0, 7));
      send_req(op, pg, r);
      if (op == rpa_pkg::REQ_ALLOC && r.status == rpa_pkg::ST_OK) begin
        held_pages.push_back(r.granted_page);
        if (held_pages.size() > 32) void'(held_pages.pop_front());
      end
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(0, 0, 12'd0, 1'b1, 12'($urandom_range(0, 4095)), 1'b0);
    run_random_phase(74, 0, 12'($urandom_range(1, 4094)), 1'b1, 12'd0, 1'b1);
    run_random_phase(0, 74, 12'hFFF, 1'b1, 12'hFFF, 1'b0);
    run_random_phase(34, 34, 12'($urandom_range(0, 2047)), 1'b0,
                     12'($urandom_range(0, 4095)), 1'b0);
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_valid = 1'b0;
    req = '0;
    rsp_ready = 1'b0;
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    mismatches = 0;
    reqs_sent = 0;
    results_seen = 0;
    cfg_writes = 0;
    peak_depth = 0;
    idle_cycles = 0;
    free_depth = 0;
    cfg_first_page = '0;
    cfg_zero_en = 1'b0;
    cfg_zero_index = '0;
    foreach (page_refs[i]) page_refs[i] = '0;
    foreach (free_list[i]) free_list[i] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_stack_fill();
    test_count_limit();
    test_random_traffic();

    hold_requests();
    repeat (20) @(posedge clk);
    $display("covered %0d requests, %0d results, %0d register writes",
             reqs_sent, results_seen, cfg_writes);
    $display("free stack peaked at %0d pages; pacing ran free, sender-gapped, stalled, mixed",
             peak_depth);
    if (mismatches == 0) begin
      $display("refcounted_page_allocator_core test passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("refcounted_page_allocator_core test failed");
    end
    $finish;
  end

endmodule
